/* hw/rtl/nlsc_pkg.sv */
package nlsc_pkg;

  // parse phase codes
  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_HEAD = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  // configuration register indexes
  localparam logic CFG_LEN_BYTES = 1'b0;
  localparam logic CFG_CODEC     = 1'b1;

  // header layout constants
  localparam logic [7:0] AVC_TYPE_MASK  = 8'h1F;
  localparam logic [7:0] HEVC_TYPE_MASK = 8'h7E;
  localparam logic [7:0] AVC_NRI_MASK   = 8'h60;
  localparam logic [7:0] AVC_AUD_TYPE   = 8'h09;
  localparam logic [5:0] HEVC_AUD_TYPE  = 6'd35;
  localparam logic [7:0] AVC_AUD_TAIL   = 8'hF0;
  localparam logic [7:0] SC_ZERO        = 8'h00;
  localparam logic [7:0] SC_ONE         = 8'h01;

  localparam int unsigned BURST_MAX = 7;

  // up to seven bytes caused by one input item, byte 0 goes out first
  typedef struct packed {
    logic [2:0]                     cnt;
    logic [BURST_MAX-1:0][7:0]      bytes;
  } burst_t;

  // prefix width with out-of-range codes folded into 1..4
  function automatic logic [2:0] prefix_width(input logic [2:0] code);
    logic [2:0] w;
    begin
      if (code == 3'd0) begin
        w = 3'd1;
      end else if (code > 3'd4) begin
        w = 3'd4;
      end else begin
        w = code;
      end
      return w;
    end
  endfunction

endpackage

/* hw/rtl/nlsc_parser.sv */
module nlsc_parser
  import nlsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       first_of_sample,
  input  logic       last_of_sample,
  input  logic [2:0] length_field_bytes,
  input  logic       codec_is_avc,
  output burst_t     burst
);

  typedef struct packed {
    burst_t burst;
    logic   seen;
    logic   drop;
  } start_res_t;

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  lbs_r, lbs_nxt;
  logic [31:0] nal_len_r, nal_len_nxt;
  logic [31:0] left_r, left_nxt;
  logic        seen_r, seen_nxt;
  logic        drop_r, drop_nxt;

  // start of a nal: keep or drop a delimiter, insert the avc delimiter
  function automatic start_res_t nal_start(input logic [7:0] hdr, input logic has_byte,
                                           input logic avc, input logic seen);
    start_res_t r;
    logic       is_aud;
    begin
      r = '0;
      if (avc) begin
        is_aud = has_byte && ((hdr & AVC_TYPE_MASK) == AVC_AUD_TYPE);
      end else begin
        is_aud = has_byte && (hdr[6:1] == HEVC_AUD_TYPE);
      end
      r.seen = 1'b1;
      if (is_aud && seen) begin
        r.drop = 1'b1;
      end else if (!seen && !is_aud && avc) begin
        r.burst.bytes[0] = (hdr & AVC_NRI_MASK) | AVC_AUD_TYPE;
        r.burst.bytes[1] = AVC_AUD_TAIL;
        r.burst.bytes[2] = SC_ZERO;
        r.burst.bytes[3] = SC_ZERO;
        r.burst.bytes[4] = SC_ZERO;
        r.burst.bytes[5] = SC_ONE;
        r.burst.bytes[6] = hdr;
        r.burst.cnt      = has_byte ? 3'd7 : 3'd6;
      end else begin
        r.burst.bytes[0] = SC_ZERO;
        r.burst.bytes[1] = SC_ZERO;
        r.burst.bytes[2] = SC_ZERO;
        r.burst.bytes[3] = SC_ONE;
        r.burst.bytes[4] = hdr;
        r.burst.cnt      = has_byte ? 3'd5 : 3'd4;
      end
      return r;
    end
  endfunction

  logic [1:0]  ph;
  logic [2:0]  lbs;
  logic [31:0] nal_len;
  logic [31:0] left;
  logic        seen;
  logic        drop;
  logic [31:0] left_dec;
  logic [31:0] nal_len_sh;
  logic [2:0]  lbs_inc;
  start_res_t  sr;

  // per-item parse step
  always_comb begin
    ph         = first_of_sample ? PH_LEN : phase_r;
    lbs        = first_of_sample ? 3'd0   : lbs_r;
    nal_len    = first_of_sample ? 32'd0  : nal_len_r;
    left       = first_of_sample ? 32'd0  : left_r;
    seen       = first_of_sample ? 1'b0   : seen_r;
    drop       = first_of_sample ? 1'b0   : drop_r;
    left_dec   = left - 32'd1;
    nal_len_sh = {nal_len[23:0], data_byte};
    lbs_inc    = lbs + 3'd1;
    sr         = nal_start(data_byte, 1'b1, codec_is_avc, seen);
    burst      = '0;
    phase_nxt  = ph;
    lbs_nxt    = lbs;
    nal_len_nxt = nal_len;
    left_nxt   = left;
    seen_nxt   = seen;
    drop_nxt   = drop;
    unique case (ph)
      PH_HEAD: begin
        burst     = sr.burst;
        seen_nxt  = sr.seen;
        drop_nxt  = sr.drop;
        left_nxt  = left_dec;
        phase_nxt = (left_dec == 32'd0) ? PH_LEN : PH_BODY;
      end
      PH_BODY: begin
        if (!drop) begin
          burst.cnt      = 3'd1;
          burst.bytes[0] = data_byte;
        end
        left_nxt  = left_dec;
        phase_nxt = (left_dec == 32'd0) ? PH_LEN : PH_BODY;
      end
      default: begin
        phase_nxt = PH_LEN;
        if (lbs_inc >= prefix_width(length_field_bytes)) begin
          lbs_nxt     = 3'd0;
          nal_len_nxt = 32'd0;
          if (nal_len_sh == 32'd0) begin
            sr       = nal_start(8'd0, 1'b0, codec_is_avc, seen);
            burst    = sr.burst;
            seen_nxt = sr.seen;
            drop_nxt = sr.drop;
          end else begin
            left_nxt  = nal_len_sh;
            phase_nxt = PH_HEAD;
          end
        end else begin
          lbs_nxt     = lbs_inc;
          nal_len_nxt = nal_len_sh;
        end
      end
    endcase
  end

  // parse state, cleared after the last byte of a sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEN;
      lbs_r     <= 3'd0;
      nal_len_r <= 32'd0;
      left_r    <= 32'd0;
      seen_r    <= 1'b0;
      drop_r    <= 1'b0;
    end else if (accept) begin
      if (last_of_sample) begin
        phase_r   <= PH_LEN;
        lbs_r     <= 3'd0;
        nal_len_r <= 32'd0;
        left_r    <= 32'd0;
        seen_r    <= 1'b0;
        drop_r    <= 1'b0;
      end else begin
        phase_r   <= phase_nxt;
        lbs_r     <= lbs_nxt;
        nal_len_r <= nal_len_nxt;
        left_r    <= left_nxt;
        seen_r    <= seen_nxt;
        drop_r    <= drop_nxt;
      end
    end
  end

endmodule

/* hw/rtl/nlsc_burst_buf.sv */
module nlsc_burst_buf
  import nlsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  burst_t     burst,
  output logic       in_ready,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       out_ready
);

  logic [2:0]                cnt_r, cnt_nxt;
  logic [BURST_MAX-1:0][7:0] data_r, data_nxt;
  logic                      take;

  // byte 0 of the held burst is on the output
  assign out_valid = (cnt_r != 3'd0);
  assign out_byte  = data_r[0];
  assign out_last  = (cnt_r == 3'd1);
  assign take      = out_valid && out_ready;
  assign in_ready  = (cnt_r == 3'd0) || (out_last && out_ready);

  // load a new burst or shift out one byte
  always_comb begin
    cnt_nxt  = cnt_r;
    data_nxt = data_r;
    if (load && (burst.cnt != 3'd0)) begin
      cnt_nxt  = burst.cnt;
      data_nxt = burst.bytes;
    end else if (take) begin
      cnt_nxt  = cnt_r - 3'd1;
      data_nxt = {8'd0, data_r[BURST_MAX-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

/* hw/rtl/nal_length_prefix_to_start_code.sv */
// Converts length-prefixed NAL units of a video sample into a start-code stream.
// Input channel: one sample byte per item in in_tdata, in_tuser marks the first
// byte of a sample and in_tlast its final byte. Each NAL length prefix is
// big-endian, cfg register 0 sets its width in bytes, register 1 picks AVC (1)
// or HEVC (0) header layout. Write configuration only while the block is idle.
// Output channel: one byte per item, out_tlast marks the final byte caused by
// one input item. An input item causes zero to seven output bytes.
// The first output byte is registered and appears in the cycle after input accept.
// Throughput: one input item per cycle while each causes at most one byte and
// the receiver is ready; an item that causes more bytes holds the input until
// the burst buffer has shifted out the last byte of that burst.
// A stalled receiver holds the current byte; new input waits until the last
// byte of the held burst is taken, so the input stays blocked for the stall.
// Reset clears the parse state and the burst buffer; registers return to a
// prefix width of four bytes and HEVC layout.
module nal_length_prefix_to_start_code
  import nlsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // data_byte
  input  logic       in_tuser,   // first_of_sample
  input  logic       in_tlast,   // last_of_sample
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic       out_tlast,  // out_last
  input  logic       cfg_we,
  input  logic       cfg_addr,
  input  logic [2:0] cfg_wdata
);

  logic [2:0] len_bytes_r;
  logic       avc_r;
  logic       accept;
  burst_t     burst;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_bytes_r <= 3'd4;
      avc_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LEN_BYTES: len_bytes_r <= cfg_wdata;
        CFG_CODEC:     avc_r       <= cfg_wdata[0];
        default:       ;
      endcase
    end
  end

  assign accept = in_tvalid && in_tready;

  nlsc_parser u_parser (
    .clk                (clk),
    .rst_n              (rst_n),
    .accept             (accept),
    .data_byte          (in_tdata),
    .first_of_sample    (in_tuser),
    .last_of_sample     (in_tlast),
    .length_field_bytes (len_bytes_r),
    .codec_is_avc       (avc_r),
    .burst              (burst)
  );

  nlsc_burst_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .burst     (burst),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_byte  (out_tdata),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

endmodule

/* hw/rtl/nlsc_checker.sv */
module nlsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  // reset empties the burst buffer
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // a stalled receiver blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input ready while output stalled");

  // no new input in the middle of a burst
  a_mid_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready in the middle of a burst");

endmodule

bind nal_length_prefix_to_start_code nlsc_checker u_nlsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import nlsc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 11;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } sample_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } annexb_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // data_byte
  logic       in_tuser;   // first_of_sample
  logic       in_tlast;   // last_of_sample
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // out_byte
  logic       out_tlast;  // out_last
  logic       cfg_we;
  logic       cfg_addr;
  logic [2:0] cfg_wdata;

  nal_length_prefix_to_start_code i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // converter state mirrored by the predictor
  logic [2:0]  cfg_prefix_code;
  logic        cfg_avc;
  logic [1:0]  parse_phase;
  logic [2:0]  len_bytes_got;
  logic [31:0] nal_len_acc;
  logic [31:0] bytes_left;
  bit          aud_seen;
  bit          skip_nal;

  annexb_byte_t annexb_expected[$];
  annexb_byte_t step_bytes[$];
  sample_byte_t pending_sample[$];
  annexb_byte_t head_byte;

  int  mismatch_count;
  int  cycle_count;
  int  items_sent;
  int  hold_cycles;
  bit  no_idle;

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------
  function automatic logic [2:0] eff_prefix_width(input logic [2:0] code);
    if (code == 3'd0) return 3'd1;
    if (code > 3'd4) return 3'd4;
    return code;
  endfunction

  function automatic bit is_delimiter(input logic [7:0] hdr);
    if (cfg_avc) return (hdr & AVC_TYPE_MASK) == AVC_AUD_TYPE;
    return hdr[6:1] == HEVC_AUD_TYPE;
  endfunction

  function automatic void clear_parse();
    parse_phase   = PH_LEN;
    len_bytes_got = '0;
    nal_len_acc   = '0;
    bytes_left    = '0;
    aud_seen      = 1'b0;
    skip_nal      = 1'b0;
  endfunction

  function automatic void emit(input logic [7:0] b);
    step_bytes.push_back('{b, 1'b0});
  endfunction

  function automatic void emit_start_code();
    emit(SC_ZERO);
    emit(SC_ZERO);
    emit(SC_ZERO);
    emit(SC_ONE);
  endfunction

  // nal header reached; zero-length nals come here with no real header byte
  function automatic void start_nal(input logic [7:0] hdr, input bit has_byte);
    bit aud;
    aud = has_byte && is_delimiter(hdr);
    if (aud) begin
      if (aud_seen) begin
        skip_nal = 1'b1;
        return;
      end
      aud_seen = 1'b1;
      skip_nal = 1'b0;
      emit_start_code();
      emit(hdr);
      return;
    end
    // first nal is not a delimiter: avc gets a synthesized one, no start code
    if (!aud_seen) begin
      aud_seen = 1'b1;
      if (cfg_avc) begin
        emit((hdr & AVC_NRI_MASK) | AVC_AUD_TYPE);
        emit(AVC_AUD_TAIL);
      end
    end
    skip_nal = 1'b0;
    emit_start_code();
    if (has_byte) emit(hdr);
  endfunction

  function automatic void predict_annexb(input sample_byte_t it);
    step_bytes.delete();
    if (it.first) clear_parse();
    case (parse_phase)
      PH_HEAD: begin
        start_nal(it.data, 1'b1);
        bytes_left--;
        parse_phase = (bytes_left == 0) ? PH_LEN : PH_BODY;
      end
      PH_BODY: begin
        if (!skip_nal) emit(it.data);
        bytes_left--;
        if (bytes_left == 0) parse_phase = PH_LEN;
      end
      default: begin
        nal_len_acc   = {nal_len_acc[23:0], it.data};
        len_bytes_got = len_bytes_got + 3'd1;
        if (len_bytes_got >= eff_prefix_width(cfg_prefix_code)) begin
          len_bytes_got = '0;
          if (nal_len_acc == 0) begin
            start_nal(8'h00, 1'b0);
            parse_phase = PH_LEN;
          end else begin
            bytes_left  = nal_len_acc;
            parse_phase = PH_HEAD;
          end
          nal_len_acc = '0;
        end else begin
          parse_phase = PH_LEN;
        end
      end
    endcase
    if (it.last) clear_parse();
    if (step_bytes.size() > 0) step_bytes[step_bytes.size()-1].last = 1'b1;
    foreach (step_bytes[k]) annexb_expected.push_back(step_bytes[k]);
  endfunction

  // --------------------------------------------------------------------------
  // output side: ready pattern and result check
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (annexb_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected output byte %02h last %0b", out_tdata, out_tlast);
      end else begin
        head_byte = annexb_expected.pop_front();
        if (out_tdata !== head_byte.data || out_tlast !== head_byte.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("output byte: expected %02h last %0b, got %02h last %0b",
                     head_byte.data, head_byte.last, out_tdata, out_tlast);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  task automatic send_item(input sample_byte_t it);
    @(negedge clk);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.data;
    in_tuser  <= it.first;
    in_tlast  <= it.last;
    do @(posedge clk); while (!in_tready);
    predict_annexb(it);
    items_sent++;
  endtask

  function automatic void add_byte(input logic [7:0] b);
    pending_sample.push_back('{b, 1'b0, 1'b0});
  endfunction

  // length prefix, then header and body
  function automatic void add_nal(input int len, input logic [7:0] hdr);
    int w;
    w = eff_prefix_width(cfg_prefix_code);
    for (int i = w - 1; i >= 0; i--) add_byte(8'(len >> (8 * i)));
    if (len > 0) add_byte(hdr);
    for (int i = 1; i < len; i++) add_byte(8'($urandom));
  endfunction

  // sends the queued bytes as one sample, flagging both ends
  task automatic send_sample();
    sample_byte_t it;
    bit head;
    head = 1'b1;
    while (pending_sample.size() != 0) begin
      it       = pending_sample.pop_front();
      it.first = head;
      it.last  = (pending_sample.size() == 0);
      head     = 1'b0;
      send_item(it);
    end
  endtask

  function automatic logic [7:0] pick_aud_header();
    logic [7:0] r;
    r = 8'($urandom);
    if (cfg_avc) return {r[7:5], AVC_AUD_TYPE[4:0]};
    return {r[7], HEVC_AUD_TYPE, r[0]};
  endfunction

  function automatic logic [7:0] pick_plain_header();
    logic [7:0] r;
    do r = 8'($urandom); while (is_delimiter(r));
    return r;
  endfunction

  // block idle: nothing offered, nothing owed, then a slack wait
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (annexb_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [2:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    if (addr == CFG_LEN_BYTES) cfg_prefix_code = value;
    else cfg_avc = value[0];
  endtask

  task automatic set_config(input logic [2:0] width_code, input logic avc);
    wait_idle();
    write_reg(CFG_LEN_BYTES, width_code);
    write_reg(CFG_CODEC, {2'($urandom), avc});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one random sample: mostly well formed, some truncated, some noise
  task automatic random_sample();
    int kind;
    int nals;
    int len;
    int w;
    int cnt;
    sample_byte_t it;
    w    = eff_prefix_width(cfg_prefix_code);
    kind = $urandom_range(99);
    if (kind < 86) begin
      nals = $urandom_range(4, 1);
      for (int i = 0; i < nals; i++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(14, 6) : $urandom_range(5);
        if (i == 0) add_nal(len, $urandom_range(1) ? pick_aud_header() : pick_plain_header());
        else add_nal(len, ($urandom_range(4) == 0) ? pick_aud_header() : pick_plain_header());
      end
      // length field cut short at the sample end
      if (kind >= 78) begin
        cnt = $urandom_range(w - 1);
        repeat (cnt) add_byte(8'($urandom));
      end
      send_sample();
    end else if (kind < 93) begin
      // huge random length, nal cut short at the sample end
      repeat (w) add_byte(8'($urandom));
      cnt = $urandom_range(6, 1);
      repeat (cnt) add_byte(8'($urandom));
      send_sample();
    end else begin
      // loose bytes with random sample flags
      cnt = $urandom_range(5, 1);
      repeat (cnt) begin
        it.data  = 8'($urandom);
        it.first = ($urandom_range(3) == 0);
        it.last  = ($urandom_range(3) == 0);
        send_item(it);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    // reset layout hevc, 4-byte prefix: kept delimiter, repeated one dropped
    add_nal(2, 8'h46);
    pending_sample[pending_sample.size()-1].data = 8'hFF;
    add_nal(1, 8'h47);
    send_sample();
    // avc, 1-byte prefix: zero-length first nal, then a plain nal
    set_config(3'd1, 1'b1);
    add_nal(0, 8'h00);
    add_nal(2, 8'hFF);
    pending_sample[pending_sample.size()-1].data = 8'h00;
    send_sample();
    // one-byte sample carrying both flags
    add_byte(8'h00);
    send_sample();
    // longest burst: synthesized delimiter, start code and header, cut short
    add_byte(8'h05);
    add_byte(8'h65);
    add_byte(8'h80);
    send_sample();
    // avc delimiter kept, second one dropped
    add_nal(1, 8'h29);
    add_nal(1, 8'h09);
    send_sample();
    // 2-byte prefix cut after one byte
    set_config(3'd2, 1'b0);
    add_byte(8'hAB);
    send_sample();
  endtask

  task automatic test_random_samples();
    logic [2:0] width_codes[8];
    int target;
    width_codes = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd5, 3'd6, 3'd7};
    for (int p = 0; p < 8; p++) begin
      set_config(width_codes[p], 1'(p[0] ^ p[2]));
      // one phase runs without any idling on either side
      no_idle = (p == 3);
      target  = items_sent + 14;
      while (items_sent < target) random_sample();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_output_stall();
    int target;
    set_config(3'd2, 1'b1);
    hold_cycles = 150;
    no_idle     = 1'b1;
    target      = items_sent + 24;
    while (items_sent < target) random_sample();
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = 1'b0;
    cfg_wdata   = '0;
    hold_cycles = 0;
    no_idle     = 1'b0;
    mismatch_count  = 0;
    cycle_count     = 0;
    items_sent      = 0;
    cfg_prefix_code = 3'd4;
    cfg_avc         = 1'b0;
    clear_parse();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_samples();
    test_output_stall();

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && annexb_expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
